### design/avbm_pkg.sv
package avbm_pkg;

    localparam int BUFFER_DEPTH_DEF = 8192;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_VOLUME  = 1'b0;
    localparam logic REG_BALANCE = 1'b1;
    localparam logic [6:0] VOLUME_RESET  = 7'd0;
    localparam logic [6:0] BALANCE_RESET = 7'd50;

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Field widths
    localparam int OFFSET_W = 13;
    localparam int INDEX_W  = 13;
    localparam int SAMPLE_W = 16;
    localparam int ADDR_SUM_W = OFFSET_W + 1;

    // Serial divider for the attenuation divide: two quotient bits per cycle
    localparam int DIV_W     = 32;
    localparam int DVS_W     = 7;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Scaling constants
    localparam logic signed [22:0] SCALE_MUL = 23'sd100;
    localparam logic signed [9:0]  BAL_FULL  = 10'sd100;
    localparam logic signed [7:0]  AMPL_FULL = 8'sd100;
    localparam logic signed [7:0]  AMPL_MIN  = 8'sd1;
    // Dividing by 50 and then by 100, both truncating, equals one division by 5000.
    // It is done as a multiplication by ceil(2^43 / 5000) followed by a shift; the
    // product of a negative dividend is rounded up by one to truncate toward zero.
    // This is exact for dividends of magnitude below 2^30.
    localparam int                RECIP_SHIFT = 43;
    localparam logic signed [31:0] RECIP_5000 = 32'sd1759218605;

    localparam logic signed [19:0] SUM_MAX = 20'sd32767;
    localparam logic signed [19:0] SUM_MIN = -20'sd32768;

    typedef struct packed {
        logic [6:0] volume_attenuation;
        logic [6:0] balance;
    } cfg_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_RDWAIT,
        ST_DIV1,
        ST_MUL,
        ST_RECIP,
        ST_QUOT,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

### design/audio_volume_balance_mixer_core.sv
// Stereo mix buffer of BUFFER_DEPTH signed 16-bit entries held in one synchronous RAM.
// Each input word carries a request: clear zeroes the whole buffer, add scales a sample
// by volume and balance and adds it with saturation to the entry at offset plus index,
// read returns that entry. Every request yields exactly one output word. One request
// is in progress at a time; s_tready is high only while the block is waiting for work,
// and a finished word waits in the output register without holding up the next request.
// An add spends most of its time in the two-bit-per-cycle serial divider for the
// attenuation divide (16 steps, then the quotient is handed over); the final divide
// by 5000 is a multiplication by its reciprocal in the RECIP and QUOT states. A read
// waits for the registered RAM output, and an unused or out-of-range request goes from
// DECODE straight to DONE. A clear sweeps one RAM entry per cycle. After reset the
// same sweep runs over all BUFFER_DEPTH entries (8192 by default) before the first
// word is accepted; configuration writes are taken throughout.
module audio_volume_balance_mixer_core
    import avbm_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,  // start_offset, sample_index, sample, zero pad
    input  logic [1:0]            s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // mixed_value
    output logic [1:0]            m_tuser,  // saturated, out_of_range
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(BUFFER_DEPTH - 1);

    state_t state_reg;
    state_t state_next;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Captured request
    logic [1:0]              req_reg;
    logic [AW-1:0]           addr_reg;
    logic                    oor_reg;
    logic                    chan_reg;
    logic signed [22:0]      s100_reg;

    // Datapath
    logic signed [22:0]      t1_reg;
    logic signed [31:0]      prod_reg;
    logic signed [63:0]      recip_reg;
    logic signed [18:0]      t2_reg;
    logic [AW-1:0]           clr_cnt_reg;

    logic [15:0]             res_value_reg;
    logic                    res_sat_reg;
    logic                    res_oor_reg;

    logic                    m_tvalid_reg;
    logic [15:0]             out_value_reg;
    logic                    out_sat_reg;
    logic                    out_oor_reg;

    // Combinational
    logic [OFFSET_W-1:0]     in_offset;
    logic [INDEX_W-1:0]      in_index;
    logic signed [22:0]      in_sample_ext;
    logic signed [22:0]      in_s100;
    logic [ADDR_SUM_W-1:0]   addr_sum;
    logic                    addr_oor;
    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    clr_last;
    logic signed [7:0]       ampl_raw;
    logic [DVS_W-1:0]        ampl;
    logic signed [9:0]       bal_ext;
    logic signed [9:0]       weight;
    logic signed [32:0]      prod;
    logic signed [63:0]      recip;
    logic signed [18:0]      quot;
    logic signed [19:0]      sum;
    logic [15:0]             sum_sat;
    logic                    sum_clip;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [15:0]             ram_wdata;
    logic [15:0]             ram_rdata;

    avbm_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    avbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    avbm_ram #(
        .WIDTH (16),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Input decode and scaling arithmetic
    always_comb
    begin
        in_offset     = s_tdata[12:0];
        in_index      = s_tdata[25:13];
        in_sample_ext = 23'(signed'(s_tdata[41:26]));
        in_s100       = in_sample_ext * SCALE_MUL;
        addr_sum      = {1'b0, in_offset} + {1'b0, in_index};
        addr_oor      = (32'(addr_sum) >= 32'(BUFFER_DEPTH));

        ampl_raw = AMPL_FULL - signed'({1'b0, cfg.volume_attenuation});
        ampl     = (ampl_raw < AMPL_MIN) ? DVS_W'(1) : DVS_W'(ampl_raw[6:0]);

        bal_ext = signed'({3'b000, cfg.balance});
        weight  = chan_reg ? 10'((BAL_FULL - bal_ext) * 10'sd2) : 10'(bal_ext * 10'sd2);
        prod    = 33'(t1_reg) * 33'(weight);

        recip = 64'(prod_reg) * 64'(RECIP_5000);
        quot  = 19'(recip_reg >>> RECIP_SHIFT) + 19'(recip_reg[63]);

        sum = 20'(t2_reg) + 20'(signed'(ram_rdata));
        if (sum > SUM_MAX)
        begin
            sum_sat  = SUM_MAX[15:0];
            sum_clip = 1'b1;
        end
        else if (sum < SUM_MIN)
        begin
            sum_sat  = SUM_MIN[15:0];
            sum_clip = 1'b1;
        end
        else
        begin
            sum_sat  = sum[15:0];
            sum_clip = 1'b0;
        end

        clr_last = (clr_cnt_reg == LAST_ENTRY);
        out_free = !m_tvalid_reg || m_tready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (req_reg)
                    REQ_CLEAR: state_next = ST_CLEAR;
                    REQ_ADD:   state_next = oor_reg ? ST_DONE : ST_DIV1;
                    REQ_READ:  state_next = oor_reg ? ST_DONE : ST_RDWAIT;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT: state_next = ST_DONE;
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_QUOT;
            ST_QUOT:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_INIT;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = sum_sat;
        div_req.start    = 1'b0;
        div_req.dividend = 32'(s100_reg);
        div_req.divisor  = ampl;
        load_out         = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:   s_tready = 1'b1;
            ST_DECODE: div_req.start = (req_reg == REQ_ADD) && !oor_reg;
            ST_SUM:    ram_we = 1'b1;
            ST_DONE:   load_out = out_free;
            default:   s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT || state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            addr_reg <= AW'(addr_sum);
            oor_reg  <= addr_oor;
            chan_reg <= in_index[0];
            s100_reg <= in_s100;
        end

        case (state_reg)
            ST_DECODE:
            begin
                res_value_reg <= '0;
                res_sat_reg   <= 1'b0;
                res_oor_reg   <= oor_reg && (req_reg inside {REQ_ADD, REQ_READ});
            end
            ST_RDWAIT: res_value_reg <= ram_rdata;
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    t1_reg <= 23'(div_rsp.quotient);
                end
            end
            ST_MUL:    prod_reg <= 32'(prod);
            ST_RECIP:  recip_reg <= recip;
            ST_QUOT:   t2_reg <= quot;
            ST_SUM:
            begin
                res_value_reg <= sum_sat;
                res_sat_reg   <= sum_clip;
            end
            default:   res_sat_reg <= res_sat_reg;
        endcase

        if (load_out)
        begin
            out_value_reg <= res_value_reg;
            out_sat_reg   <= res_sat_reg;
            out_oor_reg   <= res_oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_oor_reg, out_sat_reg};

endmodule

### design/avbm_ram.sv
module avbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/avbm_div.sv
module avbm_div
    import avbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     q_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic                 neg_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [DIV_W-1:0]     mag;
    logic [DVS_W-1:0]     rem_a;
    logic [DVS_W-1:0]     rem_b;
    logic [DIV_W-1:0]     q_a;
    logic [DIV_W-1:0]     q_b;
    logic                 last_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [DVS_W+DIV_W-1:0] div_step(
        input logic [DVS_W-1:0] rem,
        input logic [DIV_W-1:0] q,
        input logic [DVS_W-1:0] d
    );
        logic [DVS_W:0]   trial;
        logic [DIV_W-1:0] qn;
        begin
            trial = {rem, q[DIV_W-1]};
            qn    = {q[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                qn[0] = 1'b1;
            end
            return {trial[DVS_W-1:0], qn};
        end
    endfunction

    always_comb
    begin
        mag = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
        {rem_a, q_a} = div_step(rem_reg, q_reg, dvs_reg);
        {rem_b, q_b} = div_step(rem_a, q_a, dvs_reg);
        last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.dividend[DIV_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_b;
            rem_reg <= rem_b;
        end
    end

    // Truncation toward zero: the magnitude quotient takes the dividend's sign.
    always_comb
    begin
        rsp.done     = done_reg;
        rsp.quotient = neg_reg ? -signed'(q_reg) : signed'(q_reg);
    end

endmodule

### design/avbm_apb.sv
module avbm_apb
    import avbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [6:0] volume_reg;
    logic [6:0] balance_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg  <= VOLUME_RESET;
            balance_reg <= BALANCE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_VOLUME:  volume_reg  <= pwdata[6:0];
                REG_BALANCE: balance_reg <= pwdata[6:0];
                default:     volume_reg  <= volume_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_VOLUME:  prdata = APB_DATA_W'(volume_reg);
            REG_BALANCE: prdata = APB_DATA_W'(balance_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.volume_attenuation = volume_reg;
        cfg.balance            = balance_reg;
    end

endmodule
